// ----- src/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants for the bounding box accumulator.
// ----------------------------------------------------------------------------
package bba_pkg;

	localparam int unsigned FIELD_W = 32;
	localparam int unsigned AXES    = 3;
	localparam int unsigned CORNERS = 8;

	typedef logic signed [FIELD_W-1:0] field_t;
	typedef logic        [FIELD_W-1:0] ufield_t;

	// corner select: bit a set takes the maximum on axis a (x, y, z)
	typedef logic [AXES-1:0] corner_sel_t;

	// scan order for the farthest corner, earlier entries win ties
	localparam corner_sel_t CORNER_ORDER [CORNERS] = '{
		3'd7, 3'd0, 3'd6, 3'd4, 3'd5, 3'd3, 3'd2, 3'd1
	};

endpackage

// ----- src/bba_if.sv -----
// ----------------------------------------------------------------------------
// bba_if
// Point and box channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bba_point_if;
	logic           valid;
	logic           ready;
	bba_pkg::field_t px;
	bba_pkg::field_t py;
	bba_pkg::field_t pz;
	logic           last_point;

	modport source (output valid, output px, output py, output pz, output last_point,
		input ready);
	modport sink (input valid, input px, input py, input pz, input last_point,
		output ready);
endinterface

interface bba_box_if;
	logic             valid;
	logic             ready;
	bba_pkg::field_t  lo_x;
	bba_pkg::field_t  lo_y;
	bba_pkg::field_t  lo_z;
	bba_pkg::field_t  hi_x;
	bba_pkg::field_t  hi_y;
	bba_pkg::field_t  hi_z;
	bba_pkg::ufield_t span_x;
	bba_pkg::ufield_t span_y;
	bba_pkg::ufield_t span_z;
	bba_pkg::field_t  far_x;
	bba_pkg::field_t  far_y;
	bba_pkg::field_t  far_z;

	modport source (output valid, output lo_x, output lo_y, output lo_z,
		output hi_x, output hi_y, output hi_z, output span_x, output span_y,
		output span_z, output far_x, output far_y, output far_z, input ready);
	modport sink (input valid, input lo_x, input lo_y, input lo_z,
		input hi_x, input hi_y, input hi_z, input span_x, input span_y,
		input span_z, input far_x, input far_y, input far_z, output ready);
endinterface

// ----- src/bounding_box_accumulator_top.sv -----
// Throughput: one point per cycle, sustained while the box channel takes results.
// A result passes through the input register, the box snapshot and the output register
// after the edge that accepts the last point of a set.
// The running min/max update is one combinational compare-and-select per axis.
// Reset clears all valid flags and the running box, and arms the first-point flag.
// ----------------------------------------------------------------------------
// bounding_box_accumulator_top
// Running per-axis min/max over a point stream, with span and farthest corner
// reported on the last point of each set.
// ----------------------------------------------------------------------------
module bounding_box_accumulator_top #(
	parameter int unsigned COORD_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	bba_point_if.sink  pt,
	bba_box_if.source  box
);

	localparam int unsigned W = COORD_WIDTH;
	localparam int unsigned A = bba_pkg::AXES;

	typedef logic signed [W-1:0] coord_t;
	typedef logic        [W-1:0] ucoord_t;
	typedef logic signed [W:0]   wide_t;
	typedef logic        [W:0]   mag_t;

	// input stage
	logic   valid_s1;
	logic   last_s1;
	coord_t p_s1 [A];

	// running box
	logic   first_q;
	coord_t run_min_q [A];
	coord_t run_max_q [A];
	coord_t nxt_min [A];
	coord_t nxt_max [A];

	// box snapshot stage
	logic   valid_s2;
	coord_t lo_s2 [A];
	coord_t hi_s2 [A];

	// output register
	logic              out_valid_q;
	bba_pkg::field_t   lo_q   [A];
	bba_pkg::field_t   hi_q   [A];
	bba_pkg::ufield_t  span_q [A];
	bba_pkg::field_t   far_q  [A];

	// farthest corner search
	mag_t                 mag_lo [A];
	mag_t                 mag_hi [A];
	logic [A-1:0]         max_ok;
	logic [A-1:0]         min_ok;
	bba_pkg::corner_sel_t sel;
	logic                 found;
	logic                 corner_ok;
	ucoord_t              diff [A];
	bba_pkg::field_t      far_c [A];

	logic out_free;
	logic s2_free;
	logic s1_fire;
	logic load_s2;
	logic move_out;

	assign out_free = !out_valid_q || box.ready;
	assign s2_free  = !valid_s2 || out_free;
	assign s1_fire  = valid_s1 && (!last_s1 || s2_free);
	assign load_s2  = s1_fire && last_s1;
	assign move_out = valid_s2 && out_free;
	assign pt.ready = !valid_s1 || s1_fire;

	// input register, coordinates narrowed to the working width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pt.ready) begin
			valid_s1 <= pt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pt.ready && pt.valid) begin
			p_s1[0] <= coord_t'(pt.px[W-1:0]);
			p_s1[1] <= coord_t'(pt.py[W-1:0]);
			p_s1[2] <= coord_t'(pt.pz[W-1:0]);
			last_s1 <= pt.last_point;
		end
	end

	always_comb begin
		for (int a = 0; a < A; a++) begin
			if (first_q) begin
				nxt_min[a] = p_s1[a];
				nxt_max[a] = p_s1[a];
			end else begin
				nxt_min[a] = (p_s1[a] < run_min_q[a]) ? p_s1[a] : run_min_q[a];
				nxt_max[a] = (p_s1[a] > run_max_q[a]) ? p_s1[a] : run_max_q[a];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			for (int a = 0; a < A; a++) begin
				run_min_q[a] <= '0;
				run_max_q[a] <= '0;
			end
		end else if (s1_fire) begin
			first_q <= last_s1;
			for (int a = 0; a < A; a++) begin
				run_min_q[a] <= nxt_min[a];
				run_max_q[a] <= nxt_max[a];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= load_s2 || (valid_s2 && !out_free);
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			for (int a = 0; a < A; a++) begin
				lo_s2[a] <= nxt_min[a];
				hi_s2[a] <= nxt_max[a];
			end
		end
	end

	// magnitude order matches squared length order, so per axis only |hi| vs |lo|
	always_comb begin
		for (int a = 0; a < A; a++) begin
			mag_lo[a] = lo_s2[a][W-1] ? mag_t'(-wide_t'(lo_s2[a])) : mag_t'(wide_t'(lo_s2[a]));
			mag_hi[a] = hi_s2[a][W-1] ? mag_t'(-wide_t'(hi_s2[a])) : mag_t'(wide_t'(hi_s2[a]));
			max_ok[a] = mag_hi[a] >= mag_lo[a];
			min_ok[a] = mag_lo[a] >= mag_hi[a];
			diff[a]   = ucoord_t'(hi_s2[a]) - ucoord_t'(lo_s2[a]);
		end
	end

	// first corner in scan order that is maximal on every axis
	always_comb begin
		sel   = bba_pkg::CORNER_ORDER[0];
		found = 1'b0;
		for (int k = 0; k < bba_pkg::CORNERS; k++) begin
			corner_ok = 1'b1;
			for (int a = 0; a < A; a++) begin
				corner_ok = corner_ok &&
					(bba_pkg::CORNER_ORDER[k][a] ? max_ok[a] : min_ok[a]);
			end
			if (corner_ok && !found) begin
				sel   = bba_pkg::CORNER_ORDER[k];
				found = 1'b1;
			end
		end
		for (int a = 0; a < A; a++) begin
			far_c[a] = sel[a] ? bba_pkg::field_t'(hi_s2[a]) : bba_pkg::field_t'(lo_s2[a]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= move_out || (out_valid_q && !box.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (move_out) begin
			for (int a = 0; a < A; a++) begin
				lo_q[a]   <= bba_pkg::field_t'(lo_s2[a]);
				hi_q[a]   <= bba_pkg::field_t'(hi_s2[a]);
				span_q[a] <= bba_pkg::ufield_t'(diff[a]);
				far_q[a]  <= far_c[a];
			end
		end
	end

	assign box.valid  = out_valid_q;
	assign box.lo_x   = lo_q[0];
	assign box.lo_y   = lo_q[1];
	assign box.lo_z   = lo_q[2];
	assign box.hi_x   = hi_q[0];
	assign box.hi_y   = hi_q[1];
	assign box.hi_z   = hi_q[2];
	assign box.span_x = span_q[0];
	assign box.span_y = span_q[1];
	assign box.span_z = span_q[2];
	assign box.far_x  = far_q[0];
	assign box.far_y  = far_q[1];
	assign box.far_z  = far_q[2];

endmodule

// ----- src/bba_checker.sv -----
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks on the box result channel.
// ----------------------------------------------------------------------------
module bba_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             box_valid,
	input logic             box_ready,
	input bba_pkg::field_t  lo_x,
	input bba_pkg::field_t  hi_x,
	input bba_pkg::field_t  hi_y,
	input bba_pkg::field_t  lo_y,
	input bba_pkg::ufield_t span_x,
	input bba_pkg::field_t  far_x,
	input bba_pkg::field_t  far_y
);

	// a stalled result stays valid and holds its far_x and span_x values
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid && !box_ready |=> box_valid && $stable(far_x) && $stable(span_x))
		else $error("box result changed while stalled");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid |-> (lo_x <= hi_x) && (lo_y <= hi_y))
		else $error("box minimum above maximum");

	a_span: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid |-> span_x == bba_pkg::ufield_t'(hi_x - lo_x))
		else $error("span does not match corners");

	a_far: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid |-> (far_x == lo_x || far_x == hi_x) && (far_y == lo_y || far_y == hi_y))
		else $error("farthest corner is not a box corner");

endmodule

bind bounding_box_accumulator_top bba_checker u_bba_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.box_valid (box.valid),
	.box_ready (box.ready),
	.lo_x      (box.lo_x),
	.hi_x      (box.hi_x),
	.hi_y      (box.hi_y),
	.lo_y      (box.lo_y),
	.span_x    (box.span_x),
	.far_x     (box.far_x),
	.far_y     (box.far_y)
);

// ----- tb/sv/tb_bounding_box_accumulator_top.sv -----
// ----------------------------------------------------------------------------
// tb_bounding_box_accumulator_top
// Streams sets of signed Q16.16 points into the accumulator with random gaps on
// the point side and random stalls on the box side. A local model folds every
// accepted point into its own running box and queues the expected result on
// the last point of each set; every box the block returns is compared field by
// field against the oldest queued result.
// ----------------------------------------------------------------------------
module tb_bounding_box_accumulator_top;

	localparam int unsigned COORD_WIDTH = 32;
	localparam int unsigned RANDOM_POINTS = 1850;

	localparam bba_pkg::field_t COORD_MIN = 32'sh8000_0000;
	localparam bba_pkg::field_t COORD_MAX = 32'sh7FFF_FFFF;

	// corner scan order, bit a set picks the maximum on axis a
	localparam bit [2:0] SCAN [8] = '{3'd7, 3'd0, 3'd6, 3'd4, 3'd5, 3'd3, 3'd2, 3'd1};

	typedef struct {
		bba_pkg::field_t px;
		bba_pkg::field_t py;
		bba_pkg::field_t pz;
		logic            last_point;
	} point_t;

	typedef struct {
		bba_pkg::field_t  lo_x, lo_y, lo_z;
		bba_pkg::field_t  hi_x, hi_y, hi_z;
		bba_pkg::ufield_t span_x, span_y, span_z;
		bba_pkg::field_t  far_x, far_y, far_z;
	} box_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bba_point_if pt ();
	bba_box_if   box ();

	bounding_box_accumulator_top #(
		.COORD_WIDTH(COORD_WIDTH)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.pt     (pt),
		.box    (box)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	point_t      pending_points [$];
	box_t        expected_boxes [$];
	int unsigned failures = 0;

	// running box of the local model
	longint run_lo [3] = '{0, 0, 0};
	longint run_hi [3] = '{0, 0, 0};
	bit     seed_next = 1'b1;

	function automatic longint to_coord(bba_pkg::field_t raw);
		longint unsigned mask;
		longint unsigned v;
		mask = (64'd1 << COORD_WIDTH) - 64'd1;
		v = {32'd0, raw} & mask;
		if (v[COORD_WIDTH-1])
			return longint'(v) - (longint'(1) << COORD_WIDTH);
		return longint'(v);
	endfunction

	function automatic longint unsigned square(longint a);
		longint unsigned m;
		m = (a < 0) ? -a : a;
		return m * m;
	endfunction

	task automatic fold_point(point_t p);
		longint          pc [3];
		longint          corner [3];
		longint          best [3];
		longint unsigned best_len;
		longint unsigned len;
		box_t            b;
		pc[0] = to_coord(p.px);
		pc[1] = to_coord(p.py);
		pc[2] = to_coord(p.pz);
		for (int a = 0; a < 3; a++) begin
			if (seed_next) begin
				run_lo[a] = pc[a];
				run_hi[a] = pc[a];
			end else begin
				if (pc[a] > run_hi[a])
					run_hi[a] = pc[a];
				if (pc[a] < run_lo[a])
					run_lo[a] = pc[a];
			end
		end
		seed_next = 1'b0;
		if (p.last_point) begin
			best = '{0, 0, 0};
			best_len = 0;
			for (int k = 0; k < 8; k++) begin
				for (int a = 0; a < 3; a++)
					corner[a] = SCAN[k][a] ? run_hi[a] : run_lo[a];
				len = square(corner[0]) + square(corner[1]) + square(corner[2]);
				// strict compare, so earlier corners keep ties
				if (len > best_len) begin
					best_len = len;
					best = corner;
				end
			end
			b.lo_x = bba_pkg::field_t'(run_lo[0]);
			b.lo_y = bba_pkg::field_t'(run_lo[1]);
			b.lo_z = bba_pkg::field_t'(run_lo[2]);
			b.hi_x = bba_pkg::field_t'(run_hi[0]);
			b.hi_y = bba_pkg::field_t'(run_hi[1]);
			b.hi_z = bba_pkg::field_t'(run_hi[2]);
			b.span_x = bba_pkg::ufield_t'(run_hi[0] - run_lo[0]);
			b.span_y = bba_pkg::ufield_t'(run_hi[1] - run_lo[1]);
			b.span_z = bba_pkg::ufield_t'(run_hi[2] - run_lo[2]);
			b.far_x = bba_pkg::field_t'(best[0]);
			b.far_y = bba_pkg::field_t'(best[1]);
			b.far_z = bba_pkg::field_t'(best[2]);
			expected_boxes = {expected_boxes, b};
			seed_next = 1'b1;
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			failures++;
		end
	endtask

	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic bba_pkg::field_t rand_coord();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return bba_pkg::field_t'($urandom);
		if (r < 50) begin
			case ($urandom_range(0, 4))
				0: return COORD_MIN;
				1: return COORD_MAX;
				2: return bba_pkg::field_t'(-1);
				3: return bba_pkg::field_t'(1);
				default: return '0;
			endcase
		end
		if (r < 70)
			return bba_pkg::field_t'(int'($urandom_range(0, 16)) - 8);
		return bba_pkg::field_t'(int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
	endfunction

	task automatic add_point(input bba_pkg::field_t x, input bba_pkg::field_t y,
		input bba_pkg::field_t z, input logic last);
		point_t p;
		p.px = x;
		p.py = y;
		p.pz = z;
		p.last_point = last;
		pending_points = {pending_points, p};
	endtask

	// point side: driver with random gaps between items
	int unsigned src_gap;
	int unsigned src_calm;
	point_t      next_point;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt.valid <= 1'b0;
			pt.px <= '0;
			pt.py <= '0;
			pt.pz <= '0;
			pt.last_point <= 1'b0;
			src_gap <= 0;
			src_calm <= 0;
		end else begin
			// no new gaps are drawn during calm stretches
			if (src_calm != 0)
				src_calm <= src_calm - 1;
			else if ($urandom_range(0, 99) < 2)
				src_calm <= $urandom_range(30, 150);
			if (!pt.valid || pt.ready) begin
				if (src_gap != 0) begin
					pt.valid <= 1'b0;
					src_gap <= src_gap - 1;
				end else if (pending_points.size() != 0) begin
					next_point = pending_points.pop_front();
					pt.valid <= 1'b1;
					pt.px <= next_point.px;
					pt.py <= next_point.py;
					pt.pz <= next_point.pz;
					pt.last_point <= next_point.last_point;
					src_gap <= (src_calm != 0) ? 0 : idle_len();
				end else begin
					pt.valid <= 1'b0;
				end
			end
		end
	end

	// every accepted point goes through the local model
	point_t seen_point;

	always @(posedge clk) begin
		if (arst_n && pt.valid === 1'b1 && pt.ready === 1'b1) begin
			seen_point.px = pt.px;
			seen_point.py = pt.py;
			seen_point.pz = pt.pz;
			seen_point.last_point = pt.last_point;
			fold_point(seen_point);
		end
	end

	// box side: random stalls and result checking
	int unsigned snk_stall;
	int unsigned snk_calm;
	box_t        want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box.ready <= 1'b0;
			snk_stall <= 0;
			snk_calm <= 0;
		end else begin
			if (snk_calm != 0)
				snk_calm <= snk_calm - 1;
			else if ($urandom_range(0, 99) < 2)
				snk_calm <= $urandom_range(30, 150);
			if (snk_stall != 0) begin
				box.ready <= 1'b0;
				snk_stall <= snk_stall - 1;
			end else begin
				box.ready <= 1'b1;
				if (snk_calm == 0 && $urandom_range(0, 99) < 25)
					snk_stall <= idle_len();
			end
			if (box.valid === 1'b1 && box.ready === 1'b1) begin
				if (expected_boxes.size() == 0) begin
					$error("box item with no result expected");
					failures++;
				end else begin
					want = expected_boxes.pop_front();
					check_field("lo_x", want.lo_x, box.lo_x);
					check_field("lo_y", want.lo_y, box.lo_y);
					check_field("lo_z", want.lo_z, box.lo_z);
					check_field("hi_x", want.hi_x, box.hi_x);
					check_field("hi_y", want.hi_y, box.hi_y);
					check_field("hi_z", want.hi_z, box.hi_z);
					check_field("span_x", want.span_x, box.span_x);
					check_field("span_y", want.span_y, box.span_y);
					check_field("span_z", want.span_z, box.span_z);
					check_field("far_x", want.far_x, box.far_x);
					check_field("far_y", want.far_y, box.far_y);
					check_field("far_z", want.far_z, box.far_z);
				end
			end
		end
	end

	initial begin
		int unsigned random_count;
		int unsigned set_len;
		int unsigned r;

		// single-point sets at the extremes, at the origin and at -1
		add_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
		add_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
		add_point('0, '0, '0, 1'b1);
		add_point(bba_pkg::field_t'(-1), bba_pkg::field_t'(-1), bba_pkg::field_t'(-1), 1'b1);
		// full-range spans
		add_point(COORD_MIN, COORD_MAX, '0, 1'b0);
		add_point(COORD_MAX, COORD_MIN, '0, 1'b1);
		// symmetric box, every corner ties
		add_point(bba_pkg::field_t'(-5), bba_pkg::field_t'(-5), bba_pkg::field_t'(-5), 1'b0);
		add_point(bba_pkg::field_t'(5), bba_pkg::field_t'(5), bba_pkg::field_t'(5), 1'b1);
		// a later corner in the scan wins
		add_point(bba_pkg::field_t'(-10), bba_pkg::field_t'(1), bba_pkg::field_t'(1), 1'b0);
		add_point(bba_pkg::field_t'(2), bba_pkg::field_t'(2), bba_pkg::field_t'(2), 1'b1);
		// box collapsed onto the origin
		add_point('0, '0, '0, 1'b0);
		add_point('0, '0, '0, 1'b1);
		// mixed Q16.16 values over a longer set
		add_point(bba_pkg::field_t'(1), bba_pkg::field_t'(-1), 32'sh0001_0000, 1'b0);
		add_point(-32'sh0001_0000, bba_pkg::field_t'(3), bba_pkg::field_t'(-7), 1'b0);
		add_point(32'sh7FFF_0000, -32'sh7FFF_0000, bba_pkg::field_t'(5), 1'b0);
		add_point(bba_pkg::field_t'(0), COORD_MIN, COORD_MAX, 1'b0);
		add_point(bba_pkg::field_t'(-2), bba_pkg::field_t'(4), bba_pkg::field_t'(0), 1'b1);

		random_count = 0;
		while (random_count < RANDOM_POINTS) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				set_len = $urandom_range(1, 4);
			else if (r < 95)
				set_len = $urandom_range(5, 12);
			else
				set_len = $urandom_range(13, 40);
			for (int i = 0; i < set_len; i++)
				add_point(rand_coord(), rand_coord(), rand_coord(), i == set_len - 1);
			random_count += set_len;
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_points.size() != 0 || pt.valid)
			@(posedge clk);
		while (expected_boxes.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (failures == 0)
			$display("tb_bounding_box_accumulator_top passed");
		else
			$display("tb_bounding_box_accumulator_top failed");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("tb_bounding_box_accumulator_top failed");
		$finish;
	end

endmodule
